// File: src/register_log_replay_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// register_log_replay_decoder_core_macros.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef REGISTER_LOG_REPLAY_DECODER_CORE_MACROS_SVH
`define REGISTER_LOG_REPLAY_DECODER_CORE_MACROS_SVH

// same-cycle implication
`define RLRD_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("rlrd assertion failed");

// next-cycle implication
`define RLRD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("rlrd assertion failed");

`endif

// File: src/rlrd_pkg.sv
// ----------------------------------------------------------------------------
// rlrd_pkg
// Shared constants and types of the register log replay decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrd_pkg;

  localparam int unsigned LOG_DEPTH   = 8388608;
  localparam int unsigned REG_COUNT   = 32768;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned LAP_W   = $clog2(LOG_DEPTH);
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] HDR_SKIP  = 32'hFFFF_0000;
  localparam logic [WORD_W-1:0] HDR_STORE = 32'hFFFE_0002;

  localparam logic [LAP_W-1:0] LAP_LAST  = LAP_W'(LOG_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(REG_COUNT);

  localparam logic KIND_REG   = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_ADDR   = 5'b00010,
    PH_VALUE  = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic              over_range;
  } wr_cmd_t;

endpackage

`default_nettype wire

// File: src/rlrd_front.sv
// ----------------------------------------------------------------------------
// rlrd_front
// Accepts log words, tracks parse phase and lap position, emits write commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rlrd_pkg::WORD_W-1:0] log_word,
  output logic                             push_valid,
  input  wire logic                        push_ready,
  output rlrd_pkg::wr_cmd_t                push_cmd
);

  rlrd_pkg::phase_t               phase, phase_next;
  logic [rlrd_pkg::CNT_W-1:0]     words_left, words_left_next;
  logic [rlrd_pkg::IDX_W-1:0]     next_reg_index, next_reg_index_next;
  logic [rlrd_pkg::WORD_W-1:0]    store_address, store_address_next;
  logic [rlrd_pkg::LAP_W-1:0]     lap_position, lap_position_next;
  logic [rlrd_pkg::CNT_W-1:0]     words_dec;
  rlrd_pkg::phase_t               phase_dec;
  logic                           accept;
  logic                           lap_wrap;

  // any word may need a queue slot; stall the input only on a full queue
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign lap_wrap = (lap_position == rlrd_pkg::LAP_LAST);
  assign words_dec = words_left - rlrd_pkg::CNT_W'(1);

  always_comb begin
    phase_dec           = phase;
    words_left_next     = words_left;
    next_reg_index_next = next_reg_index;
    store_address_next  = store_address;
    push_valid          = 1'b0;
    push_cmd.kind       = rlrd_pkg::KIND_REG;
    push_cmd.addr       = {{(rlrd_pkg::WORD_W - rlrd_pkg::IDX_W){1'b0}}, next_reg_index};
    push_cmd.value      = log_word;
    push_cmd.over_range = (next_reg_index >= rlrd_pkg::IDX_LIMIT);

    unique case (phase)
      rlrd_pkg::PH_ADDR: begin
        store_address_next = log_word;
        phase_dec          = rlrd_pkg::PH_VALUE;
      end
      rlrd_pkg::PH_VALUE: begin
        push_valid          = accept;
        push_cmd.kind       = rlrd_pkg::KIND_STORE;
        push_cmd.addr       = store_address;
        push_cmd.over_range = 1'b0;
        phase_dec           = rlrd_pkg::PH_HEADER;
      end
      rlrd_pkg::PH_DATA: begin
        push_valid          = accept;
        next_reg_index_next = next_reg_index + rlrd_pkg::IDX_W'(1);
        words_left_next     = words_dec;
        if (words_dec == '0) phase_dec = rlrd_pkg::PH_HEADER;
      end
      rlrd_pkg::PH_SKIP: begin
        phase_dec = rlrd_pkg::PH_SKIP;
      end
      default: begin
        if (log_word == rlrd_pkg::HDR_SKIP) begin
          phase_dec = rlrd_pkg::PH_SKIP;
        end else if (log_word == rlrd_pkg::HDR_STORE) begin
          phase_dec = rlrd_pkg::PH_ADDR;
        end else begin
          next_reg_index_next = {1'b0, log_word[31:16]};
          words_left_next     = log_word[15:0];
          phase_dec = (log_word[15:0] != '0) ? rlrd_pkg::PH_DATA : rlrd_pkg::PH_HEADER;
        end
      end
    endcase

    lap_position_next = lap_wrap ? '0 : lap_position + rlrd_pkg::LAP_W'(1);

    // padding ends when the lap wraps
    if (lap_wrap && phase_dec == rlrd_pkg::PH_SKIP) phase_next = rlrd_pkg::PH_HEADER;
    else                                             phase_next = phase_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rlrd_pkg::PH_HEADER;
      words_left     <= '0;
      next_reg_index <= '0;
      store_address  <= '0;
      lap_position   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      words_left     <= words_left_next;
      next_reg_index <= next_reg_index_next;
      store_address  <= store_address_next;
      lap_position   <= lap_position_next;
    end
  end

endmodule

`default_nettype wire

// File: src/rlrd_queue.sv
// ----------------------------------------------------------------------------
// rlrd_queue
// Short FIFO of write commands between decoder and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire rlrd_pkg::wr_cmd_t push_cmd,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output rlrd_pkg::wr_cmd_t      pop_cmd
);

  rlrd_pkg::wr_cmd_t             slots [rlrd_pkg::QUEUE_DEPTH];
  logic [rlrd_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [rlrd_pkg::QCNT_W-1:0]   count;
  logic                          push, pop;

  assign push_ready = (count != rlrd_pkg::QCNT_W'(rlrd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  function automatic logic [rlrd_pkg::QPTR_W-1:0] ptr_inc(
    input logic [rlrd_pkg::QPTR_W-1:0] p
  );
    return (p == rlrd_pkg::QPTR_W'(rlrd_pkg::QUEUE_DEPTH - 1)) ? '0 :
           p + rlrd_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + rlrd_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - rlrd_pkg::QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/rlrd_back.sv
// ----------------------------------------------------------------------------
// rlrd_back
// Output register: presents one write command per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire rlrd_pkg::wr_cmd_t           pop_cmd,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             write_kind,
  output logic [rlrd_pkg::WORD_W-1:0]      target_address,
  output logic [rlrd_pkg::WORD_W-1:0]      write_value,
  output logic                             index_over_range
);

  rlrd_pkg::wr_cmd_t held;
  logic              load;

  assign pop_ready = !out_valid || out_ready;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (pop_ready) out_valid <= pop_valid;
  end

  always_ff @(posedge clk) begin
    if (load) held <= pop_cmd;
  end

  assign write_kind       = held.kind;
  assign target_address   = held.addr;
  assign write_value      = held.value;
  assign index_over_range = held.over_range;

endmodule

`default_nettype wire

// File: src/register_log_replay_decoder_core.sv
// ----------------------------------------------------------------------------
// register_log_replay_decoder_core
// Turns a ring-ordered command log into register writes and memory stores.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/log_word) takes one log word per transfer,
// padding words included. Output channel (out_valid/out_ready) gives one
// write per transfer: write_kind 0 is a register write at target_address,
// 1 a memory store; index_over_range flags register indices past the file.
// Headers, store address words and padding produce no output.
// Throughput: one word per cycle while the queue has room, set by the
// combinational decode in the front and one queue push/pop per cycle.
// A result is written into the queue at the edge that transfers its data
// word and is then loaded into the output register, which presents it until
// it is taken; while the output register is stalled it waits in the queue.
// When the receiver stalls, the output register holds and the two-entry
// queue fills; once it is full in_ready drops until a slot frees.
// Reset (rst, synchronous) empties the queue and output, clears the lap
// position and returns the parser to expecting a header.
// ----------------------------------------------------------------------------
`default_nettype none

module register_log_replay_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] log_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             write_kind,
  output logic [31:0]      target_address,
  output logic [31:0]      write_value,
  output logic             index_over_range
);

  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;
  rlrd_pkg::wr_cmd_t push_cmd, pop_cmd;

  rlrd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .log_word   (log_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  rlrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  rlrd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_cmd          (pop_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .write_kind       (write_kind),
    .target_address   (target_address),
    .write_value      (write_value),
    .index_over_range (index_over_range)
  );

endmodule

`default_nettype wire

// File: src/rlrd_checker.sv
// ----------------------------------------------------------------------------
// rlrd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_log_replay_decoder_core_macros.svh"

module rlrd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        write_kind,
  input wire logic [31:0] target_address,
  input wire logic [31:0] write_value,
  input wire logic        index_over_range
);

  logic idx_high;

  assign idx_high = (target_address[16:0] >= rlrd_pkg::IDX_LIMIT);

  // stalled result holds
  `RLRD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(write_kind) && $stable(target_address) &&
                    $stable(write_value) && $stable(index_over_range))
  // stores never carry the range flag
  `RLRD_ASSERT_NOW(a_store_flag, clk, rst, out_valid && write_kind, !index_over_range)
  // register writes: 17-bit index, flag matches the file size
  `RLRD_ASSERT_NOW(a_reg_index, clk, rst, out_valid && !write_kind,
                   target_address[31:17] == '0 && index_over_range == idx_high)
  // nothing shown right after reset
  `RLRD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind register_log_replay_decoder_core rlrd_checker u_rlrd_checker (.*);

`default_nettype wire

// File: bench/register_log_replay_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_log_replay_decoder_core_tb
// Self-checking bench for the command log decoder.
// ----------------------------------------------------------------------------
// Log words go in over valid/ready. A local decoder tracks the parse phase,
// the run counters and the lap position, and queues the expected writes.
// Each output transfer is checked field by field against the oldest one.
// Directed cases, a back-pressure stretch with a full drain among them, come
// before random header/run/store sequences with idle bursts on both sides.
// The last part runs at full rate and ends with a padding header, after
// which every word of the lap is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module register_log_replay_decoder_core_tb;

  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_WORDS = 1500;
  // several times the slowest pass with full idle bursts
  localparam int TIMEOUT_CYCLES = 200_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] log_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        write_kind;
  logic [31:0] target_address;
  logic [31:0] write_value;
  logic        index_over_range;

  // decoder state kept by the bench
  rlrd_pkg::phase_t             parse_state = rlrd_pkg::PH_HEADER;
  logic [rlrd_pkg::CNT_W-1:0]   run_left = '0;
  logic [rlrd_pkg::IDX_W-1:0]   run_index = '0;
  logic [rlrd_pkg::WORD_W-1:0]  held_addr = '0;
  logic [rlrd_pkg::LAP_W-1:0]   lap_pos = '0;

  rlrd_pkg::wr_cmd_t pending_writes[$];
  int unsigned fail_count = 0;
  longint unsigned words_fed = 0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int unsigned rx_hold_request = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_gap_left = 0;

  register_log_replay_decoder_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .log_word         (log_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .write_kind       (write_kind),
    .target_address   (target_address),
    .write_value      (write_value),
    .index_over_range (index_over_range)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  // Advance the decoder by one log word; returns 1 when a write comes out.
  function automatic bit decode_log_word(input logic [31:0] w,
                                         output rlrd_pkg::wr_cmd_t cmd);
    bit produced;
    produced = 1'b0;
    cmd = '0;
    case (parse_state)
      rlrd_pkg::PH_ADDR: begin
        held_addr = w;
        parse_state = rlrd_pkg::PH_VALUE;
      end
      rlrd_pkg::PH_VALUE: begin
        cmd.kind = rlrd_pkg::KIND_STORE;
        cmd.addr = held_addr;
        cmd.value = w;
        cmd.over_range = 1'b0;
        produced = 1'b1;
        parse_state = rlrd_pkg::PH_HEADER;
      end
      rlrd_pkg::PH_DATA: begin
        cmd.kind = rlrd_pkg::KIND_REG;
        cmd.addr = rlrd_pkg::WORD_W'(run_index);
        cmd.value = w;
        cmd.over_range = (run_index >= rlrd_pkg::IDX_LIMIT);
        produced = 1'b1;
        run_index = run_index + 1'b1;
        run_left = run_left - 1'b1;
        if (run_left == '0) parse_state = rlrd_pkg::PH_HEADER;
      end
      rlrd_pkg::PH_SKIP: ;
      default: begin
        if (w == rlrd_pkg::HDR_SKIP) begin
          parse_state = rlrd_pkg::PH_SKIP;
        end else if (w == rlrd_pkg::HDR_STORE) begin
          parse_state = rlrd_pkg::PH_ADDR;
        end else begin
          run_index = rlrd_pkg::IDX_W'(w[31:16]);
          run_left = w[15:0];
          if (run_left != '0) parse_state = rlrd_pkg::PH_DATA;
          else parse_state = rlrd_pkg::PH_HEADER;
        end
      end
    endcase
    if (lap_pos == rlrd_pkg::LAP_LAST) lap_pos = '0;
    else lap_pos = lap_pos + 1'b1;
    // padding ends at the lap wrap
    if (lap_pos == '0 && parse_state == rlrd_pkg::PH_SKIP) parse_state = rlrd_pkg::PH_HEADER;
    return produced;
  endfunction

  always @(posedge clk) begin : check_block
    rlrd_pkg::wr_cmd_t expected_write;
    rlrd_pkg::wr_cmd_t predicted_write;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_writes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected write: kind=%0d addr=%h value=%h over=%0d",
                     write_kind, target_address, write_value, index_over_range);
        end else begin
          expected_write = pending_writes.pop_front();
          if (write_kind !== expected_write.kind ||
              target_address !== expected_write.addr ||
              write_value !== expected_write.value ||
              index_over_range !== expected_write.over_range) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp kind=%0d addr=%h value=%h over=%0d",
                       expected_write.kind, expected_write.addr, expected_write.value,
                       expected_write.over_range,
                       ", got kind=%0d addr=%h value=%h over=%0d",
                       write_kind, target_address, write_value, index_over_range);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_log_word(log_word, predicted_write))
          pending_writes.push_back(predicted_write);
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      rx_gap_left = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic feed_word(input logic [31:0] w);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    log_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_fed++;
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return rlrd_pkg::HDR_SKIP;
      3: return rlrd_pkg::HDR_STORE;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_register_run(input logic [15:0] first_index,
                                   input logic [15:0] word_count);
    feed_word({first_index, word_count});
    repeat (word_count) feed_word(pick_data());
  endtask

  task automatic send_store(input logic [31:0] addr, input logic [31:0] value);
    feed_word(rlrd_pkg::HDR_STORE);
    feed_word(addr);
    feed_word(value);
  endtask

  // sender goes quiet until every expected write has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_runs();
    feed_word(32'h0000_0001);
    feed_word(32'h0000_0000);
    // last in-range index, then the first one past the file
    feed_word(32'h7FFF_0002);
    feed_word(32'hFFFF_FFFF);
    feed_word(rlrd_pkg::HDR_SKIP);
    // top start index, the store header code as plain data
    feed_word(32'hFFFF_0002);
    feed_word(rlrd_pkg::HDR_STORE);
    feed_word(32'h1234_5678);
    feed_word(32'hFFFE_0001);
    feed_word(32'h8000_0001);
  endtask

  task automatic test_zero_count_headers();
    feed_word(32'h1234_0000);
    feed_word(32'h0000_0000);
    feed_word(32'h0001_0001);
    feed_word(32'hDEAD_BEEF);
  endtask

  task automatic test_memory_stores();
    send_store(32'hFFFF_FFFF, 32'h0000_0000);
    send_store(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_request = 80;
    send_register_run(16'h0100, 16'd24);
    send_store($urandom, $urandom);
    drain_results();
    send_register_run(16'h7FFC, 16'd6);
  endtask

  // run from the top start index: indices climb past 65535
  task automatic test_top_index_run();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_register_run(16'hFFFF, 16'd40);
  endtask

  task automatic test_random_sequences();
    longint unsigned start_fed;
    int seq_no;
    int seg;
    int unsigned pick;
    logic [15:0] first_index;
    logic [15:0] word_count;
    start_fed = words_fed;
    seq_no = 0;
    while (words_fed - start_fed < RANDOM_WORDS) begin
      seg = (seq_no / 30) % 4;
      tx_idle_on = (seg % 2 == 0);
      rx_idle_on = (seg < 2);
      // final stretch at full rate
      if (words_fed - start_fed >= RANDOM_WORDS - 300) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick >= 6 && pick <= 8) begin
        send_store(pick_data(), pick_data());
      end else begin
        case ($urandom_range(0, 3))
          0: first_index = $urandom;
          1: first_index = 16'(rlrd_pkg::REG_COUNT - 4 + $urandom_range(0, 7));
          2: first_index = 16'hFFFF - 16'($urandom_range(0, 3));
          default: first_index = 16'($urandom_range(0, 15));
        endcase
        if (pick == 9) word_count = '0;
        else if ($urandom_range(0, 9) == 0) word_count = 16'($urandom_range(9, 40));
        else word_count = 16'($urandom_range(1, 8));
        // keep clear of the padding and store codes
        if ({first_index, word_count} == rlrd_pkg::HDR_SKIP ||
            {first_index, word_count} == rlrd_pkg::HDR_STORE)
          word_count++;
        send_register_run(first_index, word_count);
      end
      seq_no++;
    end
  endtask

  // padding header: everything up to the lap end is dropped
  task automatic test_padding_drop();
    int i;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    feed_word(rlrd_pkg::HDR_SKIP);
    send_store($urandom, $urandom);
    send_register_run(16'h0007, 16'd2);
    for (i = 0; i < 16; i++) feed_word(pick_data());
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_register_runs();
    test_zero_count_headers();
    test_memory_stores();
    test_backpressure();
    test_top_index_run();
    test_random_sequences();
    test_padding_drop();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/rlrd_pkg.sv
src/rlrd_front.sv
src/rlrd_queue.sv
src/rlrd_back.sv
src/register_log_replay_decoder_core.sv
src/rlrd_checker.sv
bench/register_log_replay_decoder_core_tb.sv
